// ----- rtl/char_lcd_nibble_sequencer_unit_macros.svh -----
// Assertion macros shared by the sequencer RTL.
// All checks are clocked on clk and disabled while arst_n is low.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lcdseq_pkg.sv -----
`default_nettype none
package lcdseq_pkg;

	// request kinds
	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_INSTR = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_CHAR  = 2'd3
	} act_t;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_BAD_POS  = 2'd2;

	// init run length and write index width
	localparam int unsigned INIT_LEN = 14;
	localparam int unsigned IDX_W    = $clog2(INIT_LEN);
	localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(INIT_LEN - 1);

	// timing constants (us)
	localparam logic [15:0] PWR_WAIT_US = 16'd15010;
	localparam logic [15:0] HOLD_4100   = 16'd4100;
	localparam logic [15:0] HOLD_100    = 16'd100;
	localparam logic [15:0] HOLD_40     = 16'd40;
	localparam logic [15:0] HOLD_CLEAR  = 16'd15200;
	localparam logic [15:0] HOLD_1      = 16'd1;
	localparam logic [15:0] HOLD_0      = 16'd0;

	// instruction codes; the function sets go out as a single nibble
	localparam logic [7:0] FSET8 = 8'h30;
	localparam logic [7:0] FSET4 = 8'h20;
	localparam logic [7:0] DDRAM_SET = 8'h80;

	// one bus write
	typedef struct packed {
		logic        write_valid;
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] pre_wait_us;
		logic [15:0] hold_us;
		logic [1:0]  status;
		logic        last;
	} res_t;

	// one entry of the init run
	typedef struct packed {
		logic [3:0]  nibble;
		logic [15:0] pre_wait_us;
		logic [15:0] hold_us;
	} init_wr_t;

	// power-on init: three 8-bit function sets, 4-bit switch, then
	// 0x28, 0x08, 0x01, 0x06, 0x0F as nibble pairs
	function automatic init_wr_t init_write(input logic [IDX_W-1:0] idx);
		init_wr_t w;
		w.pre_wait_us = HOLD_0;
		w.hold_us     = HOLD_40;
		w.nibble      = 4'h0;
		case (idx)
			4'd0: begin
				w.nibble = 4'h3; w.pre_wait_us = PWR_WAIT_US; w.hold_us = HOLD_4100;
			end
			4'd1:  begin w.nibble = 4'h3; w.hold_us = HOLD_100; end
			4'd2:  w.nibble = 4'h3;
			4'd3:  w.nibble = 4'h2;
			4'd4:  begin w.nibble = 4'h2; w.hold_us = HOLD_1; end
			4'd5:  w.nibble = 4'h8;
			4'd6:  begin w.nibble = 4'h0; w.hold_us = HOLD_1; end
			4'd7:  w.nibble = 4'h8;
			4'd8:  begin w.nibble = 4'h0; w.hold_us = HOLD_1; end
			4'd9:  begin w.nibble = 4'h1; w.hold_us = HOLD_CLEAR; end
			4'd10: begin w.nibble = 4'h0; w.hold_us = HOLD_1; end
			4'd11: w.nibble = 4'h6;
			4'd12: begin w.nibble = 4'h0; w.hold_us = HOLD_1; end
			4'd13: w.nibble = 4'hF;
			default: w.nibble = 4'h0;
		endcase
		return w;
	endfunction

	// printable range 0x20..0x7F
	function automatic logic char_ok(input logic [7:0] v);
		return (v[7] == 1'b0) && (v[6:5] != 2'b00);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/char_lcd_nibble_sequencer_unit.sv -----
`default_nettype none
// Channel | Signals                                        | Direction
// --------+------------------------------------------------+----------
// request | in_valid, in_stall, action, value, row, col,   | in
//         | delay_us                                       |
// write   | out_valid, out_stall, write_valid, reg_select, | out
//         | nibble, pre_wait_us, hold_us, status, last     |
//
// Each request yields 1 to 14 writes, one per cycle unless out_stall
// holds them, set by the write index counter walking the run (init 14,
// instruction 1-2, data 2, char 4; a rejection is one result).
// A new request is taken in the cycle the last write of the current one
// loads the output register, so runs follow back to back.
// out_stall holds the output register and pauses the index counter.
// arst_n clears the busy flag, the index and the output valid.
module char_lcd_nibble_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  value,
	input  wire logic [1:0]  row,
	input  wire logic [4:0]  col,
	input  wire logic [15:0] delay_us,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             write_valid,
	output logic             reg_select,
	output logic [3:0]       nibble,
	output logic [15:0]      pre_wait_us,
	output logic [15:0]      hold_us,
	output logic [1:0]       status,
	output logic             last
);
	import lcdseq_pkg::*;
	`include "char_lcd_nibble_sequencer_unit_macros.svh"

	// request register
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	act_t             act_q;
	logic [7:0]       value_q;
	logic [1:0]       row_q;
	logic [4:0]       col_q;
	logic [15:0]      delay_q;

	// output register
	logic out_valid_q;
	res_t res_q;

	res_t     gen;
	init_wr_t iw;
	logic     load;
	logic     accept;

	// output slot free or being emptied
	assign load     = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q && !(load && gen.last);
	assign accept   = in_valid && !in_stall;

	// write generation for the current index
	always_comb begin
		logic [7:0] cmd;
		logic       single;
		cmd    = DDRAM_SET | {1'b0, row_q[0], 1'b0, col_q};
		single = (value_q == FSET8) || (value_q == FSET4);
		iw     = init_write(idx_q);
		gen             = '0;
		gen.write_valid = 1'b1;
		gen.status      = ST_OK;
		case (act_q)
			ACT_INIT: begin
				gen.nibble      = iw.nibble;
				gen.pre_wait_us = iw.pre_wait_us;
				gen.hold_us     = iw.hold_us;
				gen.last        = (idx_q == INIT_LAST);
			end
			ACT_INSTR: begin
				if (single || idx_q != '0) begin
					gen.nibble  = single ? value_q[7:4] : value_q[3:0];
					gen.hold_us = delay_q;
					gen.last    = 1'b1;
				end else begin
					gen.nibble  = value_q[7:4];
					gen.hold_us = HOLD_1;
				end
			end
			ACT_DATA: begin
				if (!char_ok(value_q)) begin
					gen             = '0;
					gen.status      = ST_BAD_CHAR;
					gen.last        = 1'b1;
				end else begin
					gen.reg_select = 1'b1;
					gen.nibble     = idx_q[0] ? value_q[3:0] : value_q[7:4];
					gen.hold_us    = idx_q[0] ? HOLD_40 : HOLD_0;
					gen.last       = idx_q[0];
				end
			end
			ACT_CHAR: begin
				if (!char_ok(value_q)) begin
					gen        = '0;
					gen.status = ST_BAD_CHAR;
					gen.last   = 1'b1;
				end else if (row_q[1] || col_q[4]) begin
					gen        = '0;
					gen.status = ST_BAD_POS;
					gen.last   = 1'b1;
				end else begin
					// address set (two nibbles), then the data byte
					gen.reg_select = idx_q[1];
					if (idx_q[1])
						gen.nibble = idx_q[0] ? value_q[3:0] : value_q[7:4];
					else
						gen.nibble = idx_q[0] ? cmd[3:0] : cmd[7:4];
					if (idx_q[0])
						gen.hold_us = HOLD_40;
					else
						gen.hold_us = idx_q[1] ? HOLD_0 : HOLD_1;
					gen.last = (idx_q[1:0] == 2'd3);
				end
			end
			default: gen = '0;
		endcase
	end

	// request control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= !gen.last;
			idx_q  <= idx_q + 1'b1;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= act_t'(action);
			value_q <= value;
			row_q   <= row;
			col_q   <= col;
			delay_q <= delay_us;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load)
			res_q <= gen;
	end

	assign out_valid   = out_valid_q;
	assign write_valid = res_q.write_valid;
	assign reg_select  = res_q.reg_select;
	assign nibble      = res_q.nibble;
	assign pre_wait_us = res_q.pre_wait_us;
	assign hold_us     = res_q.hold_us;
	assign status      = res_q.status;
	assign last        = res_q.last;

	// checks
	`LCDSEQ_ASSERT_NOW(a_rej_status, out_valid_q, res_q.write_valid == (res_q.status == ST_OK), "write_valid disagrees with status")
	`LCDSEQ_ASSERT_NEXT(a_accept_start, accept, busy_q && idx_q == '0, "request not started at index zero")
	`LCDSEQ_ASSERT_NOW(a_idx_range, busy_q, idx_q <= INIT_LAST, "write index past end of run")
	`LCDSEQ_ASSERT_NEXT(a_run_continues, load && !gen.last, busy_q && out_valid_q, "run ended before its last write")

endmodule
`default_nettype wire

// ----- test/lcd_write_checker.sv -----
`default_nettype none
// Watches the request and write channels of the LCD nibble sequencer, builds
// the expected bus writes for every accepted request and checks each
// accepted write against the oldest one still waiting.
module lcd_write_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  value,
	input  wire logic [1:0]  row,
	input  wire logic [4:0]  col,
	input  wire logic [15:0] delay_us,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        write_valid,
	input  wire logic        reg_select,
	input  wire logic [3:0]  nibble,
	input  wire logic [15:0] pre_wait_us,
	input  wire logic [15:0] hold_us,
	input  wire logic [1:0]  status,
	input  wire logic        last,
	output int               mismatch_count,
	output int               pending_writes
);
	import lcdseq_pkg::*;

	// commands of the power-on sequence after the 4-bit switch
	localparam logic [7:0] CMD_FUNC_4BIT_2LINE = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_OFF     = 8'h08;
	localparam logic [7:0] CMD_CLEAR           = 8'h01;
	localparam logic [7:0] CMD_ENTRY_INC       = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON_BLINK = 8'h0F;

	// printable character window
	localparam logic [7:0] CHAR_LOW  = 8'h20;
	localparam logic [7:0] CHAR_HIGH = 8'h7F;

	// keeps the log readable when the block is badly off
	localparam int PRINT_LIMIT = 100;

	res_t expected_writes[$];
	int   write_index;

	initial begin
		mismatch_count = 0;
		pending_writes = 0;
		write_index    = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// one nibble write, not yet the end of its run
	task automatic push_write(input logic rs, input logic [3:0] nib,
			input logic [15:0] pre, input logic [15:0] hold);
		res_t w;
		w             = '0;
		w.write_valid = 1'b1;
		w.reg_select  = rs;
		w.nibble      = nib;
		w.pre_wait_us = pre;
		w.hold_us     = hold;
		w.status      = ST_OK;
		expected_writes.push_back(w);
	endtask

	// function sets to 8 or 4 bits go out as the high nibble alone
	task automatic push_instruction(input logic [7:0] code, input logic [15:0] hold,
			input logic [15:0] pre);
		if (code == FSET8 || code == FSET4) begin
			push_write(1'b0, code[7:4], pre, hold);
		end else begin
			push_write(1'b0, code[7:4], pre, HOLD_1);
			push_write(1'b0, code[3:0], HOLD_0, hold);
		end
	endtask

	task automatic push_data_byte(input logic [7:0] code);
		push_write(1'b1, code[7:4], HOLD_0, HOLD_0);
		push_write(1'b1, code[3:0], HOLD_0, HOLD_40);
	endtask

	task automatic push_rejection(input logic [1:0] code);
		res_t w;
		w        = '0;
		w.status = code;
		w.last   = 1'b1;
		expected_writes.push_back(w);
	endtask

	function automatic logic is_printable(input logic [7:0] code);
		return code >= CHAR_LOW && code <= CHAR_HIGH;
	endfunction

	// expected writes of one request, appended to the store
	task automatic predict_bus_writes(input act_t act, input logic [7:0] code,
			input logic [1:0] r, input logic [4:0] c, input logic [15:0] dly);
		res_t w;
		logic rejected;
		rejected = 1'b0;
		case (act)
			ACT_INIT: begin
				push_instruction(FSET8, HOLD_4100, PWR_WAIT_US);
				push_instruction(FSET8, HOLD_100, HOLD_0);
				push_instruction(FSET8, HOLD_40, HOLD_0);
				push_instruction(FSET4, HOLD_40, HOLD_0);
				push_instruction(CMD_FUNC_4BIT_2LINE, HOLD_40, HOLD_0);
				push_instruction(CMD_DISPLAY_OFF, HOLD_40, HOLD_0);
				push_instruction(CMD_CLEAR, HOLD_CLEAR, HOLD_0);
				push_instruction(CMD_ENTRY_INC, HOLD_40, HOLD_0);
				push_instruction(CMD_DISPLAY_ON_BLINK, HOLD_40, HOLD_0);
			end
			ACT_INSTR: push_instruction(code, dly, HOLD_0);
			ACT_DATA: begin
				if (!is_printable(code)) begin
					push_rejection(ST_BAD_CHAR);
					rejected = 1'b1;
				end else begin
					push_data_byte(code);
				end
			end
			default: begin
				// the character code is checked before the position
				if (!is_printable(code)) begin
					push_rejection(ST_BAD_CHAR);
					rejected = 1'b1;
				end else if (r > 2'd1 || c > 5'd15) begin
					push_rejection(ST_BAD_POS);
					rejected = 1'b1;
				end else begin
					push_instruction(DDRAM_SET | {1'b0, r[0], 6'b0} | {4'b0, c[3:0]},
						HOLD_40, HOLD_0);
					push_data_byte(code);
				end
			end
		endcase
		if (!rejected) begin
			w      = expected_writes.pop_back();
			w.last = 1'b1;
			expected_writes.push_back(w);
		end
	endtask

	task automatic compare_write(input res_t got, input res_t want);
		if (got.write_valid !== want.write_valid)
			report_mismatch($sformatf("write %0d write_valid %0b, expected %0b",
				write_index, got.write_valid, want.write_valid));
		if (got.reg_select !== want.reg_select)
			report_mismatch($sformatf("write %0d reg_select %0b, expected %0b",
				write_index, got.reg_select, want.reg_select));
		if (got.nibble !== want.nibble)
			report_mismatch($sformatf("write %0d nibble %h, expected %h",
				write_index, got.nibble, want.nibble));
		if (got.pre_wait_us !== want.pre_wait_us)
			report_mismatch($sformatf("write %0d pre_wait_us %0d, expected %0d",
				write_index, got.pre_wait_us, want.pre_wait_us));
		if (got.hold_us !== want.hold_us)
			report_mismatch($sformatf("write %0d hold_us %0d, expected %0d",
				write_index, got.hold_us, want.hold_us));
		if (got.status !== want.status)
			report_mismatch($sformatf("write %0d status %0d, expected %0d",
				write_index, got.status, want.status));
		if (got.last !== want.last)
			report_mismatch($sformatf("write %0d last %0b, expected %0b",
				write_index, got.last, want.last));
	endtask

	// sample both channels at the edge where a handshake completes
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_bus_writes(act_t'(action), value, row, col, delay_us);
			if (out_valid && !out_stall) begin
				got = '{write_valid, reg_select, nibble, pre_wait_us, hold_us, status, last};
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("write %0d arrived with none expected",
						write_index));
				end else begin
					want = expected_writes.pop_front();
					compare_write(got, want);
				end
				write_index++;
			end
			pending_writes = expected_writes.size();
		end
	end

endmodule
`default_nettype wire

// ----- test/tb_char_lcd_nibble_sequencer_unit.sv -----
`default_nettype none
module tb_char_lcd_nibble_sequencer_unit;
	import lcdseq_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int RANDOM_REQUESTS = 400;
	localparam int LONG_HOLD       = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int TIMEOUT_CYCLES  = 800000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [1:0]  action    = ACT_INIT;
	logic [7:0]  value     = '0;
	logic [1:0]  row       = '0;
	logic [4:0]  col       = '0;
	logic [15:0] delay_us  = '0;
	logic        out_stall = 1'b0;

	wire logic        in_stall;
	wire logic        out_valid;
	wire logic        write_valid;
	wire logic        reg_select;
	wire logic [3:0]  nibble;
	wire logic [15:0] pre_wait_us;
	wire logic [15:0] hold_us;
	wire logic [1:0]  status;
	wire logic        last;

	int   mismatch_count;
	int   pending_writes;
	int   writes_taken  = 0;
	logic steady_sender = 1'b0;

	always #CLK_HALF clk = ~clk;

	char_lcd_nibble_sequencer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.value       (value),
		.row         (row),
		.col         (col),
		.delay_us    (delay_us),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_valid (write_valid),
		.reg_select  (reg_select),
		.nibble      (nibble),
		.pre_wait_us (pre_wait_us),
		.hold_us     (hold_us),
		.status      (status),
		.last        (last)
	);

	lcd_write_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.value          (value),
		.row            (row),
		.col            (col),
		.delay_us       (delay_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.write_valid    (write_valid),
		.reg_select     (reg_select),
		.nibble         (nibble),
		.pre_wait_us    (pre_wait_us),
		.hold_us        (hold_us),
		.status         (status),
		.last           (last),
		.mismatch_count (mismatch_count),
		.pending_writes (pending_writes)
	);

	// offer one request after a random gap and wait until it is taken
	task automatic send_request(input act_t act, input logic [7:0] v, input logic [1:0] r,
			input logic [4:0] c, input logic [15:0] d);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		value    <= v;
		row      <= r;
		col      <= c;
		delay_us <= d;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// mostly well-formed requests; some bad codes and positions as noise
	task automatic send_random_request();
		int          pick;
		logic [7:0]  v;
		logic [1:0]  r;
		logic [4:0]  c;
		logic [15:0] d;
		pick = $urandom_range(0, 99);
		v    = 8'($urandom);
		r    = 2'($urandom);
		c    = 5'($urandom);
		d    = 16'($urandom);
		if (pick < 4) begin
			send_request(ACT_INIT, v, r, c, d);
		end else if (pick < 34) begin
			if ($urandom_range(0, 7) == 0)
				v = $urandom_range(0, 1) ? FSET8 : FSET4;
			send_request(ACT_INSTR, v, r, c, d);
		end else if (pick < 64) begin
			if ($urandom_range(0, 4) != 0)
				v = 8'($urandom_range(8'h20, 8'h7F));
			send_request(ACT_DATA, v, r, c, d);
		end else begin
			if ($urandom_range(0, 4) != 0) begin
				v = 8'($urandom_range(8'h20, 8'h7F));
				r = 2'($urandom_range(0, 1));
				c = 5'($urandom_range(0, 15));
			end
			send_request(ACT_CHAR, v, r, c, d);
		end
	endtask

	// request side: reset, directed cases, random traffic, drain, verdict
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACT_INIT, 8'h00, 2'd0, 5'd0, 16'h0000);
		// single-nibble function sets, then two-nibble instructions at the extremes
		send_request(ACT_INSTR, FSET8, 2'd3, 5'd31, 16'h0000);
		send_request(ACT_INSTR, FSET4, 2'd0, 5'd0, 16'hFFFF);
		send_request(ACT_INSTR, 8'h00, 2'd3, 5'd31, 16'hFFFF);
		send_request(ACT_INSTR, 8'hFF, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_INSTR, 8'h31, 2'd1, 5'd16, 16'h5AA5);
		// data bytes at both edges of the printable window
		send_request(ACT_DATA, 8'h1F, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_DATA, 8'h20, 2'd3, 5'd31, 16'hFFFF);
		send_request(ACT_DATA, 8'h7F, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_DATA, 8'h80, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_DATA, 8'h00, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_DATA, 8'hFF, 2'd0, 5'd0, 16'h0000);
		// characters at the corners and just outside them
		send_request(ACT_CHAR, 8'h41, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_CHAR, 8'h7F, 2'd1, 5'd15, 16'hFFFF);
		send_request(ACT_CHAR, 8'h20, 2'd2, 5'd0, 16'h0000);
		send_request(ACT_CHAR, 8'h41, 2'd1, 5'd16, 16'h0000);
		send_request(ACT_CHAR, 8'h41, 2'd3, 5'd31, 16'h0000);
		// bad code together with bad position reports the code
		send_request(ACT_CHAR, 8'h10, 2'd3, 5'd31, 16'h0000);
		send_request(ACT_CHAR, 8'hFF, 2'd0, 5'd0, 16'h0000);
		send_request(ACT_INIT, 8'hFF, 2'd3, 5'd31, 16'hFFFF);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady_sender = (i >= 150 && i < 200);
			send_random_request();
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (pending_writes != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[char_lcd_nibble_sequencer_unit] OK");
		else
			$display("[char_lcd_nibble_sequencer_unit] ERROR");
		$finish;
	end

	// write side: random stalls, an idle-free stretch, two long hold-offs
	initial begin
		int hold;
		forever begin
			if (writes_taken == 150 || writes_taken == 900)
				hold = LONG_HOLD;
			else if (writes_taken >= 400 && writes_taken < 550)
				hold = 0;
			else
				hold = $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			writes_taken++;
		end
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("[char_lcd_nibble_sequencer_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/lcdseq_pkg.sv
rtl/char_lcd_nibble_sequencer_unit.sv
test/lcd_write_checker.sv
test/tb_char_lcd_nibble_sequencer_unit.sv
